// ===== sv/npps_pkg.sv =====
// Shared types and widths for the priority scheduler.
// Used by npps_cell and the top level; depends on nothing else.
`default_nettype none

package npps_pkg;

    localparam int ID_W    = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 23;
    localparam int SUM_W   = 29;

    // One stored job.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_job;

    // Candidate record carried down the chain during one scan.
    // hit:  best job already arrived at the current time.
    // pend: best job among the earliest pending arrivals.
    typedef struct packed {
        logic  go;
        logic  hit;
        t_job  hit_job;
        logic  pend;
        t_job  pend_job;
    } t_tok;

    // Broadcast control from the sequencer to one cell.
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              mark;
        logic [TIME_W-1:0] now;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/npps_cell.sv =====
// One table slot of the scheduler chain: holds a job and its done flag,
// and merges its job into the candidate record passing by. Uses npps_pkg.
`default_nettype none

module npps_cell #(
    parameter int SLOT_W   = 4,
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire npps_pkg::t_cell_ctl i_ctl,
    input  wire [CNT_W-1:0]          i_count,
    input  wire npps_pkg::t_job      i_job,
    input  wire npps_pkg::t_tok      i_tok,
    input  wire [SLOT_W-1:0]         i_hit_slot,
    input  wire [SLOT_W-1:0]         i_pend_slot,
    output npps_pkg::t_tok           o_tok,
    output logic [SLOT_W-1:0]        o_hit_slot,
    output logic [SLOT_W-1:0]        o_pend_slot
);

    npps_pkg::t_job r_job;
    logic           r_done;
    npps_pkg::t_tok n_tok;
    logic           w_live;
    logic           w_elig;
    logic           w_hit_win;
    logic           w_pend_win;

    assign w_live = (CNT_W'(CELL_IDX) < i_count) && !r_done;
    assign w_elig = w_live && (npps_pkg::TIME_W'(r_job.arr) <= i_ctl.now);

    // Priority first, then arrival, then id; a full tie keeps the lower slot.
    assign w_hit_win = w_elig && (!i_tok.hit
        || (r_job.prio < i_tok.hit_job.prio)
        || ((r_job.prio == i_tok.hit_job.prio)
            && ((r_job.arr < i_tok.hit_job.arr)
                || ((r_job.arr == i_tok.hit_job.arr)
                    && (r_job.id < i_tok.hit_job.id)))));

    // Earliest arrival first, then priority, then id.
    assign w_pend_win = w_live && (!i_tok.pend
        || (r_job.arr < i_tok.pend_job.arr)
        || ((r_job.arr == i_tok.pend_job.arr)
            && ((r_job.prio < i_tok.pend_job.prio)
                || ((r_job.prio == i_tok.pend_job.prio)
                    && (r_job.id < i_tok.pend_job.id)))));

    always_comb begin
        n_tok = i_tok;
        if (w_hit_win) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_job = r_job;
        end
        if (w_pend_win) begin
            n_tok.pend     = 1'b1;
            n_tok.pend_job = r_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_job <= i_job;
        end
        if (!i_rst_n) begin
            o_tok <= '0;
        end else begin
            o_tok <= n_tok;
        end
        o_hit_slot  <= w_hit_win ? SLOT_W'(CELL_IDX) : i_hit_slot;
        o_pend_slot <= w_pend_win ? SLOT_W'(CELL_IDX) : i_pend_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr || i_ctl.wr) begin
            r_done <= 1'b0;
        end else if (i_ctl.mark) begin
            r_done <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nonpreemptive_priority_scheduler_unit.sv =====
// Top level of the non-preemptive priority scheduler: job chain and sequencer.
// Depends on npps_pkg and npps_cell.
`default_nettype none

// Non-preemptive priority scheduler. Load a set of jobs one beat at a time
// (id, arrival, burst, priority); a beat with last_job high closes the set and
// returns the first scheduled job. Every further input beat (its fields are
// ignored) returns the next scheduled job, until the beat flagged last_result,
// which also carries the total turnaround and waiting times and empties the
// table for the next set. A load beat with last_job low returns nothing; a job
// offered to a full table is dropped, but its last_job still closes the set.
// Among arrived, unfinished jobs the smallest priority wins, then earlier
// arrival, then smaller id, then lower slot; if none has arrived, time jumps
// to the earliest pending arrival, and time starts at the earliest arrival of
// the set. For a beat that yields a result, the candidate record walks the chain
// of MAX_PROCS slot cells one cell per cycle, followed by the completion-time
// add, the turnaround and waiting subtracts, and the sum update. The output
// register lets a load beat be taken while a result still waits downstream.
module nonpreemptive_priority_scheduler_unit #(
    parameter int MAX_PROCS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_job_id,
    input  wire  [15:0] i_arrival_time,
    input  wire  [15:0] i_burst_time,
    input  wire  [7:0]  i_priority_req,
    input  wire         i_last_job,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_done_id,
    output logic [22:0] o_completion_time,
    output logic [22:0] o_turnaround_time,
    output logic [22:0] o_waiting_time,
    output logic        o_last_result,
    output logic [28:0] o_total_turnaround,
    output logic [28:0] o_total_waiting
);

    localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DIFF,
        S_EMIT
    } t_state;

    t_state r_state;

    // Set-level state.
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_finished;
    logic                        r_running;
    logic                        r_closing;
    logic                        r_start;
    logic [npps_pkg::TIME_W-1:0] r_time;
    logic [npps_pkg::SUM_W-1:0]  r_tat_sum;
    logic [npps_pkg::SUM_W-1:0]  r_wt_sum;

    // Selected job, carried through the arithmetic steps.
    logic [npps_pkg::ID_W-1:0]    r_sel_id;
    logic [npps_pkg::ARR_W-1:0]   r_sel_arr;
    logic [npps_pkg::ARR_W:0]     r_sel_ab;
    logic [SLOT_W-1:0]            r_sel_slot;
    logic [npps_pkg::TIME_W-1:0]  r_tat;
    logic [npps_pkg::TIME_W-1:0]  r_wt;
    logic                         r_last;

    // Chain wiring: index k feeds cell k, index MAX_PROCS is the chain output.
    npps_pkg::t_tok           w_tok       [0:MAX_PROCS];
    logic [SLOT_W-1:0]        w_hit_slot  [0:MAX_PROCS];
    logic [SLOT_W-1:0]        w_pend_slot [0:MAX_PROCS];
    npps_pkg::t_cell_ctl      w_ctl       [0:MAX_PROCS-1];
    logic [MAX_PROCS-1:0]     w_mark;
    npps_pkg::t_job           w_in_job;

    logic                        w_in_acc;
    logic                        w_emit;
    logic                        w_use_hit;
    npps_pkg::t_job              w_sel;
    logic [SLOT_W-1:0]           w_sel_slot;
    logic [npps_pkg::TIME_W-1:0] w_base;
    logic [npps_pkg::SUM_W-1:0]  w_tat_sum;
    logic [npps_pkg::SUM_W-1:0]  w_wt_sum;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_emit     = (r_state == S_EMIT) && (!o_out_valid || i_out_ready);

    assign w_in_job = '{id: i_job_id, arr: i_arrival_time, burst: i_burst_time,
                        prio: i_priority_req};

    // Inject an empty record at the head of the chain to start a scan.
    always_comb begin
        w_tok[0]    = '0;
        w_tok[0].go = r_start;
    end
    assign w_hit_slot[0]  = '0;
    assign w_pend_slot[0] = '0;

    for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
        assign w_mark[k]     = w_emit && !r_last && (r_sel_slot == SLOT_W'(k));
        assign w_ctl[k].wr   = w_in_acc && !r_running && (r_count == CNT_W'(k));
        assign w_ctl[k].clr  = w_emit && r_last;
        assign w_ctl[k].mark = w_mark[k];
        assign w_ctl[k].now  = r_time;

        npps_cell #(
            .SLOT_W   (SLOT_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[k]),
            .i_count     (r_count),
            .i_job       (w_in_job),
            .i_tok       (w_tok[k]),
            .i_hit_slot  (w_hit_slot[k]),
            .i_pend_slot (w_pend_slot[k]),
            .o_tok       (w_tok[k+1]),
            .o_hit_slot  (w_hit_slot[k+1]),
            .o_pend_slot (w_pend_slot[k+1])
        );
    end

    // On the closing beat time starts at the earliest arrival, which is what
    // the pending candidate gives; otherwise fall back to it only when no
    // job has arrived yet (time jumps forward to that arrival).
    assign w_use_hit  = !r_closing && w_tok[MAX_PROCS].hit;
    assign w_sel      = w_use_hit ? w_tok[MAX_PROCS].hit_job : w_tok[MAX_PROCS].pend_job;
    assign w_sel_slot = w_use_hit ? w_hit_slot[MAX_PROCS] : w_pend_slot[MAX_PROCS];
    assign w_base     = w_use_hit ? r_time : npps_pkg::TIME_W'(w_sel.arr);

    assign w_tat_sum = r_tat_sum + npps_pkg::SUM_W'(r_tat);
    assign w_wt_sum  = r_wt_sum + npps_pkg::SUM_W'(r_wt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_finished  <= '0;
            r_running   <= 1'b0;
            r_closing   <= 1'b0;
            r_start     <= 1'b0;
            r_time      <= '0;
            r_tat_sum   <= '0;
            r_wt_sum    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_out_valid && i_out_ready && !w_emit) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (!r_running) begin
                            // Drop the job when the table is full.
                            if (r_count < CNT_W'(MAX_PROCS)) begin
                                r_count <= r_count + 1'b1;
                            end
                            if (i_last_job) begin
                                r_running <= 1'b1;
                                r_closing <= 1'b1;
                                r_start   <= 1'b1;
                                r_state   <= S_SCAN;
                            end
                        end else begin
                            r_closing <= 1'b0;
                            r_start   <= 1'b1;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Wait for the record to leave the last cell.
                    if (w_tok[MAX_PROCS].go) begin
                        r_time     <= w_base + npps_pkg::TIME_W'(w_sel.burst);
                        r_sel_id   <= w_sel.id;
                        r_sel_arr  <= w_sel.arr;
                        r_sel_ab   <= {1'b0, w_sel.arr} + {1'b0, w_sel.burst};
                        r_sel_slot <= w_sel_slot;
                        r_state    <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_tat   <= r_time - npps_pkg::TIME_W'(r_sel_arr);
                    r_wt    <= r_time - npps_pkg::TIME_W'(r_sel_ab);
                    r_last  <= (CNT_W'(r_finished + 1'b1) == r_count);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Hold until the output register is free.
                    if (w_emit) begin
                        o_out_valid        <= 1'b1;
                        o_done_id          <= r_sel_id;
                        o_completion_time  <= r_time;
                        o_turnaround_time  <= r_tat;
                        o_waiting_time     <= r_wt;
                        o_last_result      <= r_last;
                        o_total_turnaround <= r_last ? w_tat_sum : '0;
                        o_total_waiting    <= r_last ? w_wt_sum : '0;
                        if (r_last) begin
                            // Set complete: empty the table and start over.
                            r_count    <= '0;
                            r_finished <= '0;
                            r_running  <= 1'b0;
                            r_time     <= '0;
                            r_tat_sum  <= '0;
                            r_wt_sum   <= '0;
                        end else begin
                            r_finished <= r_finished + 1'b1;
                            r_tat_sum  <= w_tat_sum;
                            r_wt_sum   <= w_wt_sum;
                        end
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // A scan record only leaves the chain while the sequencer waits for it.
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_PROCS].go |-> (r_state == S_SCAN))
        else $error("scan record left the chain outside a scan");

    // The table never holds more jobs than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PROCS))
        else $error("job count beyond table size");

    // At most one slot is retired per result.
    a_mark_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_mark))
        else $error("more than one slot marked done");

    // No job is reported done before the set is closed.
    a_idle_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_finished == '0))
        else $error("finished count nonzero while loading");

endmodule

`default_nettype wire

// ===== dv/nonpreemptive_priority_scheduler_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the non-preemptive priority scheduler: directed and random job sets.
// Depends on npps_pkg for the job record and on nonpreemptive_priority_scheduler_unit.

module nonpreemptive_priority_scheduler_unit_tb;

    localparam int SLOTS        = 16;
    // One result beat walks the whole chain plus the arithmetic stages.
    localparam int RESULT_LAT   = SLOTS + 4;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_BEATS  = 260;
    localparam logic [31:0] NO_PENDING = 32'hFFFF_FFFF;

    // One scheduled job as the block reports it.
    typedef struct packed {
        logic [7:0]  id;
        logic [22:0] completion;
        logic [22:0] turnaround;
        logic [22:0] waiting;
        logic        set_done;
        logic [28:0] tot_turnaround;
        logic [28:0] tot_waiting;
    } sched_result_t;

    // Track the job table, compute the schedule and hold the results still owed.
    class sched_scoreboard;
        npps_pkg::t_job job_slots[SLOTS];
        bit            finished_flag[SLOTS];
        int unsigned   n_jobs;
        int unsigned   n_done;
        logic [22:0]   now_tick;
        logic [28:0]   tat_sum;
        logic [28:0]   wt_sum;
        bit            draining;
        sched_result_t owed_q[$];
        int            errors;

        function new();
            errors = 0;
            clear_set();
        endfunction

        function void clear_set();
            for (int i = 0; i < SLOTS; i++) begin
                job_slots[i]     = '0;
                finished_flag[i] = 1'b0;
            end
            n_jobs   = 0;
            n_done   = 0;
            now_tick = '0;
            tat_sum  = '0;
            wt_sum   = '0;
            draining = 1'b0;
        endfunction

        // Priority first, then earlier arrival, then smaller id; equal keeps the lower slot.
        function bit ranks_ahead(int a, int b);
            if (job_slots[a].prio != job_slots[b].prio)
                return job_slots[a].prio < job_slots[b].prio;
            if (job_slots[a].arr != job_slots[b].arr)
                return job_slots[a].arr < job_slots[b].arr;
            return job_slots[a].id < job_slots[b].id;
        endfunction

        function int pick_runnable();
            int best;
            best = -1;
            for (int i = 0; i < int'(n_jobs); i++) begin
                if (finished_flag[i] || {7'b0, job_slots[i].arr} > now_tick) continue;
                if (best < 0 || ranks_ahead(i, best)) best = i;
            end
            return best;
        endfunction

        function logic [31:0] earliest_pending();
            logic [31:0] m;
            m = NO_PENDING;
            for (int i = 0; i < int'(n_jobs); i++)
                if (!finished_flag[i] && {16'b0, job_slots[i].arr} < m)
                    m = {16'b0, job_slots[i].arr};
            return m;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Account for one accepted input beat; queue the job it schedules, if any.
        function void note_input(npps_pkg::t_job job, bit close_set);
            int            w;
            logic [31:0]   nx;
            logic [22:0]   tat;
            logic [22:0]   wt;
            sched_result_t r;
            if (!draining) begin
                // A full table drops the job, but its close flag still counts.
                if (n_jobs < SLOTS) begin
                    job_slots[n_jobs]     = job;
                    finished_flag[n_jobs] = 1'b0;
                    n_jobs++;
                end
                if (!close_set) return;
                draining = 1'b1;
                n_done   = 0;
                nx       = earliest_pending();
                now_tick = nx[22:0];
            end
            w = pick_runnable();
            if (w < 0) begin
                // Nothing has arrived yet: jump ahead to the next arrival.
                nx = earliest_pending();
                if (nx != NO_PENDING && nx > {9'b0, now_tick}) now_tick = nx[22:0];
                w = pick_runnable();
            end
            if (w < 0) begin
                clear_set();
                return;
            end
            now_tick = now_tick + {7'b0, job_slots[w].burst};
            tat      = now_tick - {7'b0, job_slots[w].arr};
            wt       = tat - {7'b0, job_slots[w].burst};
            finished_flag[w] = 1'b1;
            n_done++;
            tat_sum  = tat_sum + {6'b0, tat};
            wt_sum   = wt_sum + {6'b0, wt};
            r.id             = job_slots[w].id;
            r.completion     = now_tick;
            r.turnaround     = tat;
            r.waiting        = wt;
            r.set_done       = (n_done >= n_jobs);
            r.tot_turnaround = r.set_done ? tat_sum : '0;
            r.tot_waiting    = r.set_done ? wt_sum : '0;
            owed_q.push_back(r);
            if (r.set_done) clear_set();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result against the oldest owed one.
        function void check_result(sched_result_t got);
            sched_result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: result beat with no job owed: expected none, actual id %0d",
                         $time, got.id);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            check_field("done_id",          32'(want.id),             32'(got.id));
            check_field("completion_time",  32'(want.completion),     32'(got.completion));
            check_field("turnaround_time",  32'(want.turnaround),     32'(got.turnaround));
            check_field("waiting_time",     32'(want.waiting),        32'(got.waiting));
            check_field("last_result",      32'(want.set_done),       32'(got.set_done));
            check_field("total_turnaround", 32'(want.tot_turnaround), 32'(got.tot_turnaround));
            check_field("total_waiting",    32'(want.tot_waiting),    32'(got.tot_waiting));
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_job_id       = '0;
    logic [15:0] i_arrival_time = '0;
    logic [15:0] i_burst_time   = '0;
    logic [7:0]  i_priority_req = '0;
    logic        i_last_job     = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_done_id;
    logic [22:0] o_completion_time;
    logic [22:0] o_turnaround_time;
    logic [22:0] o_waiting_time;
    logic        o_last_result;
    logic [28:0] o_total_turnaround;
    logic [28:0] o_total_waiting;

    sched_scoreboard sched_sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int quiet_cycles   = 0;

    nonpreemptive_priority_scheduler_unit #(
        .MAX_PROCS(SLOTS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_job_id           (i_job_id),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_priority_req     (i_priority_req),
        .i_last_job         (i_last_job),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_done_id          (o_done_id),
        .o_completion_time  (o_completion_time),
        .o_turnaround_time  (o_turnaround_time),
        .o_waiting_time     (o_waiting_time),
        .o_last_result      (o_last_result),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: stall ready at random, check every accepted beat, and run the
    // watchdog. Everything here samples the values from before the edge.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sched_sb.check_result({o_done_id, o_completion_time, o_turnaround_time,
                                       o_waiting_time, o_last_result,
                                       o_total_turnaround, o_total_waiting});
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one beat and hold it until the block takes it. Valid stays high on
    // exit, so a following beat goes out back to back.
    task automatic send_beat(npps_pkg::t_job job, bit close_set);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_job_id       <= job.id;
        i_arrival_time <= job.arr;
        i_burst_time   <= job.burst;
        i_priority_req <= job.prio;
        i_last_job     <= close_set;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sched_sb.note_input(job, close_set);
        beats_sent++;
    endtask

    task automatic send_job(logic [7:0] id, logic [15:0] arr, logic [15:0] burst,
                            logic [7:0] prio, bit close_set);
        npps_pkg::t_job job;
        job.id    = id;
        job.arr   = arr;
        job.burst = burst;
        job.prio  = prio;
        send_beat(job, close_set);
    endtask

    // Pull the rest of the schedule out with beats of random content, which
    // the block ignores while draining (a stray last_job included).
    task automatic drain_set();
        while (sched_sb.draining)
            send_job(8'($urandom_range(255)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sched_sb.pending() != 0) @(posedge i_clk);
    endtask

    // One random job set: mostly small, some full, a few past the table size so
    // late jobs get dropped. Narrow modes force ties on priority and arrival.
    task automatic run_random_set();
        int   n;
        int   arr_mode;
        int   burst_mode;
        bit   tie_prio;
        bit   tie_id;
        npps_pkg::t_job job;
        n = $urandom_range(99);
        if (n < 60)      n = $urandom_range(4, 1);
        else if (n < 90) n = $urandom_range(SLOTS, 5);
        else             n = $urandom_range(SLOTS + 3, SLOTS);
        arr_mode   = $urandom_range(3);
        burst_mode = $urandom_range(3);
        tie_prio   = 1'($urandom_range(1));
        tie_id     = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
            job.id = tie_id ? 8'($urandom_range(3)) : 8'($urandom_range(255));
            case (arr_mode)
                0: job.arr = 16'($urandom_range(65535));
                1: job.arr = 16'($urandom_range(7));
                2: job.arr = 16'($urandom_range(65535, 65528));
                default: job.arr = 16'($urandom_range(200));
            endcase
            case (burst_mode)
                0: job.burst = 16'($urandom_range(65535));
                1: job.burst = 16'($urandom_range(3));
                2: job.burst = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
                default: job.burst = 16'($urandom_range(50));
            endcase
            job.prio = tie_prio ? 8'($urandom_range(2)) : 8'($urandom_range(255));
            send_beat(job, i == n - 1);
        end
        drain_set();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lone job at the top of every field, then at the bottom.
        send_job(8'd255, 16'd65535, 16'd65535, 8'd255, 1'b1);
        send_job(8'd0, 16'd0, 16'd0, 8'd0, 1'b1);

        // Ties: same priority at one arrival, a slot-only tie (same id, arrival
        // and priority), a later arrival, and a top-priority job arriving later.
        send_job(8'd7, 16'd10, 16'd3, 8'd2, 1'b0);
        send_job(8'd3, 16'd10, 16'd4, 8'd2, 1'b0);
        send_job(8'd3, 16'd10, 16'd5, 8'd2, 1'b0);
        send_job(8'd1, 16'd12, 16'd1, 8'd2, 1'b0);
        send_job(8'd9, 16'd20, 16'd6, 8'd0, 1'b1);
        drain_set();

        // Idle gap: the first job ends long before the second arrives.
        send_job(8'd4, 16'd100, 16'd5, 8'd9, 1'b0);
        send_job(8'd6, 16'd5000, 16'd2, 8'd1, 1'b1);
        drain_set();

        // Idling phases: none, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            int target;
            send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 27 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 27 : 0;
            wait_quiet();
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(9) == 0) wait_quiet();
                run_random_set();
            end
        end

        wait_quiet();
        repeat (2 * RESULT_LAT) @(posedge i_clk);
        if (sched_sb.errors == 0 && sched_sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
